@@ hdl/marker_framed_command_decoder_top_defines.svh @@
// assertion helpers for the frame decoder
`ifndef MARKER_FRAMED_COMMAND_DECODER_TOP_DEFINES_SVH
`define MARKER_FRAMED_COMMAND_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MFCD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mfcd check failed");

// next-cycle implication, checked outside reset
`define MFCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mfcd check failed");

`endif

@@ hdl/mfcd_pkg.sv @@
package mfcd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 7;
    localparam int unsigned CMD_W   = 5;
    localparam int unsigned CFG_IDX_W = 1;

    // number of defined commands
    localparam logic [BYTE_W-1:0] COMMAND_COUNT = 8'd21;

    // register reset values and indexes
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hA5;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h5A;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;

    // one decoded result
    typedef struct packed {
        logic               data_write;
        logic [INDEX_W-1:0] data_index;
        logic [BYTE_W-1:0]  data_byte;
        logic               frame_done;
        logic [CMD_W-1:0]   frame_command;
    } t_result;

    // payload length per command
    function automatic logic [INDEX_W-1:0] payload_length_of(input logic [CMD_W-1:0] cmd);
        logic [INDEX_W-1:0] len;
        begin
            case (cmd)
                5'd8:          len = 7'd4;
                5'd17, 5'd18:  len = 7'd84;
                5'd19:         len = 7'd28;
                default:       len = 7'd0;
            endcase
            return len;
        end
    endfunction

endpackage

@@ hdl/mfcd_frame_fsm.sv @@
module mfcd_frame_fsm (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mfcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mfcd_pkg::BYTE_W-1:0]       i_cfg_data,
    input  logic                              i_accept,
    input  logic [mfcd_pkg::BYTE_W-1:0]       i_rx_byte,
    output mfcd_pkg::t_result                 o_result
);
    import mfcd_pkg::*;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_START   = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_END     = 2'd3;

    logic [BYTE_W-1:0]  r_start_marker;
    logic [BYTE_W-1:0]  r_end_marker;
    logic [1:0]         r_phase, n_phase;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [INDEX_W-1:0] r_length, n_length;
    logic [INDEX_W-1:0] r_count, n_count;
    logic [INDEX_W-1:0] count_inc;
    logic [INDEX_W-1:0] table_len;

    assign count_inc = r_count + 7'd1;
    assign table_len = payload_length_of(i_rx_byte[CMD_W-1:0]);

    // marker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_end_marker   <= END_MARKER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next frame state and result for the current byte
    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_length = r_length;
        n_count  = r_count;
        o_result = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_rx_byte == r_start_marker) n_phase = PH_START;
            end
            PH_START: begin
                if (i_rx_byte < COMMAND_COUNT) begin
                    n_cmd    = i_rx_byte[CMD_W-1:0];
                    n_length = table_len;
                    n_count  = '0;
                    n_phase  = (table_len == '0) ? PH_END : PH_PAYLOAD;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_PAYLOAD: begin
                o_result.data_write = 1'b1;
                o_result.data_index = r_count;
                o_result.data_byte  = i_rx_byte;
                n_count = count_inc;
                if (count_inc == r_length) n_phase = PH_END;
            end
            default: begin
                if (i_rx_byte == r_end_marker) begin
                    o_result.frame_done    = 1'b1;
                    o_result.frame_command = r_cmd;
                end
                n_phase = PH_IDLE;
            end
        endcase
    end

    // frame state, advanced once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cmd    <= '0;
            r_length <= '0;
            r_count  <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_length <= n_length;
            r_count  <= n_count;
        end
    end

endmodule

@@ hdl/mfcd_result_reg.sv @@
module mfcd_result_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load_valid,
    output logic               o_load_ready,
    input  mfcd_pkg::t_result  i_result,
    output logic               o_valid,
    input  logic               i_ready,
    output mfcd_pkg::t_result  o_result
);
    import mfcd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // free when empty or drained this cycle
    assign o_load_ready = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load_ready) begin
            r_valid <= i_load_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_load_ready && i_load_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hdl/marker_framed_command_decoder_top.sv @@
// a request accepted at one edge has its result registered and valid after that edge
// throughput: one request per cycle; the result register stalls intake only while
// a held result is not taken
// reset: synchronous active low; frame returns to idle, markers to 0xA5 / 0x5A,
// result register empties
module marker_framed_command_decoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mfcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mfcd_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                            i_rx_valid,
    output logic                            o_rx_ready,
    input  logic [mfcd_pkg::BYTE_W-1:0]     i_rx_byte,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic                            o_data_write,
    output logic [mfcd_pkg::INDEX_W-1:0]    o_data_index,
    output logic [mfcd_pkg::BYTE_W-1:0]     o_data_byte,
    output logic                            o_frame_done,
    output logic [mfcd_pkg::CMD_W-1:0]      o_frame_command
);
    import mfcd_pkg::*;

`include "marker_framed_command_decoder_top_defines.svh"

    logic    accept;
    t_result dec_result;
    t_result out_result;

    assign accept = i_rx_valid && o_rx_ready;

    // frame tracking and decode
    mfcd_frame_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .o_result   (dec_result)
    );

    // result register
    mfcd_result_reg u_res (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (i_rx_valid),
        .o_load_ready (o_rx_ready),
        .i_result     (dec_result),
        .o_valid      (o_res_valid),
        .i_ready      (i_res_ready),
        .o_result     (out_result)
    );

    assign o_data_write    = out_result.data_write;
    assign o_data_index    = out_result.data_index;
    assign o_data_byte     = out_result.data_byte;
    assign o_frame_done    = out_result.frame_done;
    assign o_frame_command = out_result.frame_command;

    // a result is a payload write or a frame close, never both
    `MFCD_ASSERT_SAME(a_write_xor_done, o_res_valid, !(o_data_write && o_frame_done))
    // no write means empty index and byte fields
    `MFCD_ASSERT_SAME(a_idle_fields, o_res_valid && !o_data_write, ~|o_data_index && ~|o_data_byte)
    // a held result blocks new requests
    `MFCD_ASSERT_SAME(a_stall_blocks, o_res_valid && !i_res_ready, !o_rx_ready)
    // every accepted request yields a result next cycle
    `MFCD_ASSERT_NEXT(a_accept_result, i_rx_valid && o_rx_ready, o_res_valid)

endmodule
